// ===== rtl/emx_pkg.sv =====
package emx_pkg;

  localparam int FIELD_W = 31;
  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [FIELD_W-1:0] MODULUS_RST = 31'd7907;
  localparam logic [FIELD_W-1:0] GENERATOR_RST = 31'd17;
  localparam logic [FIELD_W-1:0] KEY_RST = 31'd2753;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY = 2'd2;

  localparam logic [1:0] ACT_PUBKEY = 2'd0;
  localparam logic [1:0] ACT_ENCRYPT = 2'd1;
  localparam logic [1:0] ACT_DECRYPT = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_PW_START,
    S_PW_SQR,
    S_PW_MUL,
    S_PW_NEXT,
    S_MUL_WAIT,
    S_PUB_END,
    S_ENC_E2,
    S_ENC_C1,
    S_ENC_C2,
    S_DEC_S,
    S_EUC_TEST,
    S_DIV_WAIT,
    S_EUC_UPD,
    S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SET_GK,
    OP_SET_CK,
    OP_PW_INIT,
    OP_SHIFT_EX,
    OP_SAVE_R1,
    OP_SAVE_E2,
    OP_SAVE_C1,
    OP_EUC_INIT,
    OP_EUC_UPD,
    OP_FLAG,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    MS_RED,
    MS_SQR,
    MS_MULB,
    MS_MSG,
    MS_DEC,
    MS_QT
  } msel_t;

  typedef struct packed {
    op_t   op;
    logic  mul_start;
    msel_t msel;
    logic  div_start;
  } cmd_t;

  typedef struct packed {
    logic       mul_done;
    logic       div_done;
    logic       ex_msb;
    logic       r1_zero;
    logic       r0_one;
    logic       p_zero;
    logic       p_small;
    logic [1:0] action;
  } status_t;

endpackage

// ===== rtl/emx_dp.sv =====
module emx_dp #(
  parameter int W = 31
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [emx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [emx_pkg::FIELD_W-1:0]       cfg_data,
  input  logic [1:0]                        in_action,
  input  logic [emx_pkg::FIELD_W-1:0]       in_message,
  input  logic [emx_pkg::FIELD_W-1:0]       in_nonce,
  input  logic [emx_pkg::FIELD_W-1:0]       in_c1,
  input  logic [emx_pkg::FIELD_W-1:0]       in_c2,
  input  emx_pkg::cmd_t                     cmd,
  output emx_pkg::status_t                  status,
  output logic [W-1:0]                      out_first,
  output logic [W-1:0]                      out_second,
  output logic                              out_flag
);
  import emx_pkg::*;

  localparam int CW = $clog2(W);

  logic [W-1:0] p, gen, key;
  logic [1:0]   act;
  logic [W-1:0] msg, nonce, c1, c2;
  logic [W-1:0] bsrc, bred, pw, ex, e2;
  logic [W-1:0] res1, res2;
  logic         flag;
  logic [W-1:0] er0, er1, et0, et1, q, rem, tmp;

  // shift-add modular multiplier
  logic [W-1:0]  ma, mb, macc;
  logic [CW-1:0] mcnt;
  logic          mbusy, mdone;
  msel_t         msel_q;
  logic [W-1:0]  a_sel, b_sel;
  logic [W+1:0]  mt, m1, m2, pp;
  logic [W-1:0]  mres;
  logic          mlast;

  // restoring divider
  logic [W-1:0]  dq, drem;
  logic [CW-1:0] dcnt;
  logic          dbusy, ddone;
  logic [W:0]    dsh, dsub;
  logic          dge;
  logic [W-1:0]  drem_n, dq_n;

  logic [W-1:0]  one;
  logic [W:0]    tdiff, twrap;
  logic [W-1:0]  tnew;

  assign one = {{(W-1){1'b0}}, (p != W'(1))};

  always_comb begin
    case (cmd.msel)
      MS_RED:  begin a_sel = bsrc;  b_sel = one; end
      MS_SQR:  begin a_sel = pw;    b_sel = pw;  end
      MS_MULB: begin a_sel = pw;    b_sel = bred; end
      MS_MSG:  begin a_sel = msg;   b_sel = pw;  end
      MS_DEC:  begin a_sel = c2;    b_sel = et0; end
      MS_QT:   begin a_sel = q;     b_sel = et1; end
      default: begin a_sel = '0;    b_sel = '0;  end
    endcase
  end

  assign pp = {2'b00, p};
  assign mt = {1'b0, macc, 1'b0} + (ma[W-1] ? {2'b00, mb} : '0);
  assign m1 = (mt >= pp) ? mt - pp : mt;
  assign m2 = (m1 >= pp) ? m1 - pp : m1;
  assign mres = m2[W-1:0];
  assign mlast = mbusy && (mcnt == '0);

  assign dsh = {drem, dq[W-1]};
  assign dsub = dsh - {1'b0, er1};
  assign dge = (dsh >= {1'b0, er1});
  assign drem_n = dge ? dsub[W-1:0] : dsh[W-1:0];
  assign dq_n = {dq[W-2:0], dge};

  assign tdiff = {1'b0, et0} - {1'b0, tmp};
  assign twrap = {1'b0, et0} + {1'b0, p} - {1'b0, tmp};
  assign tnew = (et0 >= tmp) ? tdiff[W-1:0] : twrap[W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p <= MODULUS_RST[W-1:0];
      gen <= GENERATOR_RST[W-1:0];
      key <= KEY_RST[W-1:0];
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODULUS:   p <= cfg_data[W-1:0];
        REG_GENERATOR: gen <= cfg_data[W-1:0];
        REG_KEY:       key <= cfg_data[W-1:0];
        default:       ;
      endcase
    end
  end

  // unit control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
      dbusy <= 1'b0;
      ddone <= 1'b0;
    end else begin
      mdone <= mlast;
      ddone <= dbusy && (dcnt == '0);
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
      end else if (mlast) begin
        mbusy <= 1'b0;
      end
      if (cmd.div_start) begin
        dbusy <= 1'b1;
      end else if (dbusy && (dcnt == '0)) begin
        dbusy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma <= a_sel;
      mb <= b_sel;
      macc <= '0;
      mcnt <= CW'(W - 1);
      msel_q <= cmd.msel;
    end else if (mbusy) begin
      ma <= {ma[W-2:0], 1'b0};
      macc <= mres;
      mcnt <= mcnt - 1'b1;
    end

    if (cmd.div_start) begin
      dq <= er0;
      drem <= '0;
      dcnt <= CW'(W - 1);
    end else if (dbusy) begin
      dq <= dq_n;
      drem <= drem_n;
      dcnt <= dcnt - 1'b1;
      if (dcnt == '0) begin
        q <= dq_n;
        rem <= drem_n;
      end
    end

    if (mlast) begin
      case (msel_q)
        MS_RED:  bred <= mres;
        MS_SQR:  pw <= mres;
        MS_MULB: pw <= mres;
        MS_MSG:  res2 <= mres;
        MS_DEC:  res1 <= mres;
        MS_QT:   tmp <= mres;
        default: ;
      endcase
    end

    case (cmd.op)
      OP_LOAD: begin
        act <= in_action;
        msg <= in_message[W-1:0];
        nonce <= in_nonce[W-1:0];
        c1 <= in_c1[W-1:0];
        c2 <= in_c2[W-1:0];
        res1 <= '0;
        res2 <= '0;
        flag <= 1'b0;
      end
      OP_SET_GK: begin
        bsrc <= gen;
        ex <= key;
      end
      OP_SET_CK: begin
        bsrc <= c1;
        ex <= key;
      end
      OP_PW_INIT:  pw <= one;
      OP_SHIFT_EX: ex <= {ex[W-2:0], 1'b0};
      OP_SAVE_R1:  res1 <= pw;
      OP_SAVE_E2: begin
        e2 <= pw;
        bsrc <= gen;
        ex <= nonce;
      end
      OP_SAVE_C1: begin
        res1 <= pw;
        bsrc <= e2;
        ex <= nonce;
      end
      OP_EUC_INIT: begin
        er0 <= p;
        er1 <= pw;
        et0 <= '0;
        et1 <= one;
      end
      OP_EUC_UPD: begin
        er0 <= er1;
        er1 <= rem;
        et0 <= et1;
        et1 <= tnew;
      end
      OP_FLAG: flag <= 1'b1;
      OP_EMIT: begin
        out_first <= res1;
        out_second <= res2;
        out_flag <= flag;
      end
      default: ;
    endcase
  end

  assign status.mul_done = mdone;
  assign status.div_done = ddone;
  assign status.ex_msb = ex[W-1];
  assign status.r1_zero = (er1 == '0);
  assign status.r0_one = (er0 == W'(1));
  assign status.p_zero = (p == '0);
  assign status.p_small = (p < W'(2));
  assign status.action = act;

endmodule

// ===== rtl/emx_ctrl.sv =====
module emx_ctrl #(
  parameter int W = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  emx_pkg::status_t  status,
  output emx_pkg::cmd_t     cmd
);
  import emx_pkg::*;

  localparam int CW = $clog2(W);

  state_t        state, state_next;
  state_t        ret, ret_next;
  state_t        post, post_next;
  logic [CW-1:0] bcnt, bcnt_next;
  logic          out_valid, out_valid_next;
  logic          emit_ok;

  assign emit_ok = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      post <= S_IDLE;
      bcnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ret <= ret_next;
      post <= post_next;
      bcnt <= bcnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next = ret;
    post_next = post;
    bcnt_next = bcnt;
    case (state)
      S_IDLE: if (s_tvalid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (status.p_zero) begin
          state_next = S_EMIT;
        end else begin
          case (status.action)
            ACT_PUBKEY: begin
              post_next = S_PUB_END;
              state_next = S_PW_START;
            end
            ACT_ENCRYPT: begin
              post_next = S_ENC_E2;
              state_next = S_PW_START;
            end
            ACT_DECRYPT: begin
              post_next = S_DEC_S;
              state_next = status.p_small ? S_EMIT : S_PW_START;
            end
            default: state_next = S_EMIT;
          endcase
        end
      end
      S_PW_START: begin
        bcnt_next = CW'(W - 1);
        ret_next = S_PW_SQR;
        state_next = S_MUL_WAIT;
      end
      S_PW_SQR: begin
        ret_next = S_PW_MUL;
        state_next = S_MUL_WAIT;
      end
      S_PW_MUL: begin
        ret_next = S_PW_NEXT;
        state_next = status.ex_msb ? S_MUL_WAIT : S_PW_NEXT;
      end
      S_PW_NEXT: begin
        if (bcnt == '0) begin
          state_next = post;
        end else begin
          bcnt_next = bcnt - 1'b1;
          state_next = S_PW_SQR;
        end
      end
      S_MUL_WAIT: if (status.mul_done) state_next = ret;
      S_PUB_END: state_next = S_EMIT;
      S_ENC_E2: begin
        post_next = S_ENC_C1;
        state_next = S_PW_START;
      end
      S_ENC_C1: begin
        post_next = S_ENC_C2;
        state_next = S_PW_START;
      end
      S_ENC_C2: begin
        ret_next = S_EMIT;
        state_next = S_MUL_WAIT;
      end
      S_DEC_S: state_next = S_EUC_TEST;
      S_EUC_TEST: begin
        if (status.r1_zero) begin
          ret_next = S_EMIT;
          state_next = status.r0_one ? S_MUL_WAIT : S_EMIT;
        end else begin
          state_next = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          ret_next = S_EUC_UPD;
          state_next = S_MUL_WAIT;
        end
      end
      S_EUC_UPD: state_next = S_EUC_TEST;
      S_EMIT: if (emit_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    cmd.mul_start = 1'b0;
    cmd.msel = MS_RED;
    cmd.div_start = 1'b0;
    s_tready = 1'b0;
    out_valid_next = (out_valid && !m_tready);
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) cmd.op = OP_LOAD;
      end
      S_DISPATCH: begin
        if (status.p_zero) begin
          if (status.action == ACT_DECRYPT) cmd.op = OP_FLAG;
        end else begin
          case (status.action)
            ACT_PUBKEY, ACT_ENCRYPT: cmd.op = OP_SET_GK;
            ACT_DECRYPT: cmd.op = status.p_small ? OP_FLAG : OP_SET_CK;
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      S_PW_START: begin
        cmd.op = OP_PW_INIT;
        cmd.mul_start = 1'b1;
        cmd.msel = MS_RED;
      end
      S_PW_SQR: begin
        cmd.mul_start = 1'b1;
        cmd.msel = MS_SQR;
      end
      S_PW_MUL: begin
        cmd.mul_start = status.ex_msb;
        cmd.msel = MS_MULB;
      end
      S_PW_NEXT: cmd.op = OP_SHIFT_EX;
      S_PUB_END: cmd.op = OP_SAVE_R1;
      S_ENC_E2:  cmd.op = OP_SAVE_E2;
      S_ENC_C1:  cmd.op = OP_SAVE_C1;
      S_ENC_C2: begin
        cmd.mul_start = 1'b1;
        cmd.msel = MS_MSG;
      end
      S_DEC_S: cmd.op = OP_EUC_INIT;
      S_EUC_TEST: begin
        if (status.r1_zero) begin
          if (status.r0_one) begin
            cmd.mul_start = 1'b1;
            cmd.msel = MS_DEC;
          end else begin
            cmd.op = OP_FLAG;
          end
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.mul_start = 1'b1;
          cmd.msel = MS_QT;
        end
      end
      S_EUC_UPD: cmd.op = OP_EUC_UPD;
      S_EMIT: begin
        if (emit_ok) begin
          cmd.op = OP_EMIT;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign m_tvalid = out_valid;

endmodule

// ===== rtl/elgamal_modexp_engine.sv =====
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  action, message, nonce, cipher_first, cipher_second
// m_*       out        m_tvalid/m_tready  result_first, result_second, no_inverse
// cfg_*     in         cfg_we             register index, write data
//
// One item at a time. Each modular multiply is a shift-add loop over the bits
// of its first operand; a power takes up to 2*W+1 of them, so public key is
// one power, encrypt three powers, decrypt one power plus an extended Euclid
// loop of a divide and a multiply per step. Synchronous reset restores the
// register defaults. The next item is taken once the result sits in the
// output register, even while m_tready is low.
module elgamal_modexp_engine #(
  parameter int OPERAND_WIDTH = 31
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // action, message, nonce, cipher_first, cipher_second, zero pad
  input  logic [emx_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // result_first, result_second, no_inverse, zero pad
  output logic [emx_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [emx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [emx_pkg::FIELD_W-1:0]       cfg_data
);
  import emx_pkg::*;

  localparam int W = OPERAND_WIDTH;

  cmd_t         cmd;
  status_t      status;
  logic [W-1:0] out_first, out_second;
  logic         out_flag;

  emx_ctrl #(.W(W)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  emx_dp #(.W(W)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_action  (s_tdata[1:0]),
    .in_message (s_tdata[32:2]),
    .in_nonce   (s_tdata[63:33]),
    .in_c1      (s_tdata[94:64]),
    .in_c2      (s_tdata[125:95]),
    .cmd        (cmd),
    .status     (status),
    .out_first  (out_first),
    .out_second (out_second),
    .out_flag   (out_flag)
  );

  assign m_tdata = {1'b0, out_flag, FIELD_W'(out_second), FIELD_W'(out_first)};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in work");

  a_flag_zero_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[62]) |-> (m_tdata[61:0] == '0))
    else $error("no_inverse with nonzero result");

  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |=> !status.mul_done)
    else $error("multiplier done right after start");

endmodule

// ===== sim/tb.sv =====
module tb;
  import emx_pkg::*;

  // action code with no operation behind it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] second;
    logic               no_inv;
  } elg_result_t;

  class elgamal_tracker;
    longint unsigned p_mod, gen, key;
    elg_result_t     pending_results[$];
    int              errors;

    function new();
      p_mod = MODULUS_RST;
      gen = GENERATOR_RST;
      key = KEY_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
      if (idx == REG_MODULUS) p_mod = val;
      else if (idx == REG_GENERATOR) gen = val;
      else if (idx == REG_KEY) key = val;
    endfunction

    function longint unsigned mul_mod(longint unsigned a, longint unsigned b);
      return ((a % p_mod) * (b % p_mod)) % p_mod;
    endfunction

    function longint unsigned pow_mod(longint unsigned b, longint unsigned e);
      longint unsigned acc;
      acc = 1 % p_mod;
      for (int i = FIELD_W - 1; i >= 0; i--) begin
        acc = mul_mod(acc, acc);
        if (e[i]) acc = mul_mod(acc, b);
      end
      return acc;
    endfunction

    // extended Euclid; returns 0 when gcd != 1
    function bit inv_mod(longint unsigned a, output longint unsigned inv);
      longint r0, r1, t0, t1, q, tmp;
      r0 = p_mod;
      r1 = a % p_mod;
      t0 = 0;
      t1 = 1;
      inv = 0;
      while (r1 != 0) begin
        q = r0 / r1;
        tmp = r0 - q * r1; r0 = r1; r1 = tmp;
        tmp = t0 - q * t1; t0 = t1; t1 = tmp;
      end
      if (r0 != 1) return 0;
      if (t0 < 0) t0 += p_mod;
      inv = longint'(t0) % p_mod;
      return 1;
    endfunction

    function elg_result_t predict(logic [1:0] act, logic [FIELD_W-1:0] msg,
                                  logic [FIELD_W-1:0] r, logic [FIELD_W-1:0] c1,
                                  logic [FIELD_W-1:0] c2);
      elg_result_t res;
      longint unsigned e2, s, inv;
      res.first = '0;
      res.second = '0;
      res.no_inv = 1'b0;
      if (p_mod == 0) begin
        if (act == ACT_DECRYPT) res.no_inv = 1'b1;
      end else if (act == ACT_PUBKEY) begin
        res.first = FIELD_W'(pow_mod(gen, key));
      end else if (act == ACT_ENCRYPT) begin
        e2 = pow_mod(gen, key);
        res.first = FIELD_W'(pow_mod(gen, r));
        res.second = FIELD_W'(mul_mod(msg, pow_mod(e2, r)));
      end else if (act == ACT_DECRYPT) begin
        if (p_mod < 2) begin
          res.no_inv = 1'b1;
        end else begin
          s = pow_mod(c1, key);
          if (inv_mod(s, inv)) res.first = FIELD_W'(mul_mod(c2, inv));
          else res.no_inv = 1'b1;
        end
      end
      return res;
    endfunction

    function void note(logic [1:0] act, logic [FIELD_W-1:0] msg, logic [FIELD_W-1:0] r,
                       logic [FIELD_W-1:0] c1, logic [FIELD_W-1:0] c2);
      pending_results.push_back(predict(act, msg, r, c1, c2));
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check(logic [OUT_DATA_W-1:0] d);
      elg_result_t exp_r;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      exp_r = pending_results.pop_front();
      if (d[FIELD_W-1:0] !== exp_r.first)
        report($sformatf("result_first %h, want %h", d[FIELD_W-1:0], exp_r.first));
      if (d[2*FIELD_W-1:FIELD_W] !== exp_r.second)
        report($sformatf("result_second %h, want %h", d[2*FIELD_W-1:FIELD_W],
                         exp_r.second));
      if (d[2*FIELD_W] !== exp_r.no_inv)
        report($sformatf("no_inverse %b, want %b", d[2*FIELD_W], exp_r.no_inv));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0] cfg_data = '0;

  elgamal_tracker trk = new();
  bit quiet = 1'b0;
  int sink_hold = 0;

  elgamal_modexp_engine dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #(8 * 40_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // sink side: random stall bursts with m_tready low
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      sink_hold <= $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) trk.check(m_tdata);

  task send(logic [1:0] act, logic [FIELD_W-1:0] msg, logic [FIELD_W-1:0] r,
            logic [FIELD_W-1:0] c1, logic [FIELD_W-1:0] c2);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, c2, c1, r, msg, act};
    do @(posedge clk); while (!s_tready);
    trk.note(act, msg, r, c1, c2);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (trk.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    trk.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task set_all(logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] g, logic [FIELD_W-1:0] k);
    write_reg(REG_MODULUS, p);
    write_reg(REG_GENERATOR, g);
    write_reg(REG_KEY, k);
  endtask

  // encrypt, then decrypt the predicted ciphertext
  task round_trip(logic [FIELD_W-1:0] msg, logic [FIELD_W-1:0] r);
    elg_result_t ct;
    ct = trk.predict(ACT_ENCRYPT, msg, r, '0, '0);
    send(ACT_ENCRYPT, msg, r, rnd31(), rnd31());
    send(ACT_DECRYPT, rnd31(), rnd31(), ct.first, ct.second);
  endtask

  function logic [FIELD_W-1:0] rnd31();
    return FIELD_W'($urandom);
  endfunction

  function logic [FIELD_W-1:0] pick_modulus();
    case ($urandom_range(0, 6))
      0: return 31'h7fff_ffff;
      1: return 31'd65521;
      2: return 31'd7919;
      3: return 31'd3;
      4: return 31'd221;
      5: return 31'd2;
      default: return rnd31();
    endcase
  endfunction

  initial begin
    int n;
    logic [FIELD_W-1:0] max31;
    max31 = '1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults
    send(ACT_PUBKEY, '0, '0, '0, '0);
    send(ACT_ENCRYPT, '0, '0, '0, '0);
    send(ACT_ENCRYPT, max31, max31, max31, max31);
    round_trip(31'd1234, 31'd77);
    send(ACT_DECRYPT, '0, '0, '0, 31'd5);
    send(ACT_UNUSED, max31, max31, max31, max31);
    // largest prime, all-ones generator and key
    set_all(max31, max31, max31);
    send(ACT_PUBKEY, max31, max31, max31, max31);
    round_trip(max31, max31);
    // composite modulus: shared secret sharing a factor has no inverse
    set_all(31'd221, '0, '0);
    send(ACT_PUBKEY, '0, '0, '0, '0);
    send(ACT_ENCRYPT, 31'd9, 31'd4, '0, '0);
    write_reg(REG_KEY, 31'd5);
    send(ACT_DECRYPT, '0, '0, 31'd13, 31'd100);
    send(ACT_DECRYPT, '0, '0, 31'd2, 31'd100);
    // modulus one and zero
    set_all(31'd1, 31'd3, 31'd4);
    send(ACT_PUBKEY, '0, '0, '0, '0);
    send(ACT_ENCRYPT, 31'd5, 31'd6, '0, '0);
    send(ACT_DECRYPT, '0, '0, 31'd7, 31'd8);
    write_reg(REG_MODULUS, '0);
    send(ACT_PUBKEY, '0, '0, '0, '0);
    send(ACT_ENCRYPT, 31'd5, 31'd6, '0, '0);
    send(ACT_DECRYPT, '0, '0, 31'd7, 31'd8);
    send(ACT_UNUSED, '0, '0, '0, '0);

    for (int ph = 0; ph < 5; ph++) begin
      set_all(pick_modulus(), ($urandom_range(0, 1) ? rnd31() : 31'($urandom_range(0, 50))),
              rnd31());
      if (ph == 4) quiet = 1'b1;
      n = 0;
      while (n < 24) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            round_trip(rnd31(), rnd31());
            n += 1;
          end
          5: send(ACT_PUBKEY, rnd31(), rnd31(), rnd31(), rnd31());
          6: send(ACT_ENCRYPT, rnd31(), rnd31(), rnd31(), rnd31());
          7: send(ACT_DECRYPT, rnd31(), rnd31(), rnd31(), rnd31());
          8: send(ACT_DECRYPT, rnd31(), rnd31(), '0, rnd31());
          default: send(ACT_UNUSED, rnd31(), rnd31(), rnd31(), rnd31());
        endcase
        n++;
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (trk.pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (trk.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== elgamal_modexp_engine.f =====
rtl/emx_pkg.sv
rtl/emx_dp.sv
rtl/emx_ctrl.sv
rtl/elgamal_modexp_engine.sv
sim/tb.sv
